// ===== rtl/spcb_pkg.sv =====
// Package for the sync point counter bank.
// Holds stream widths, access codes and parameter defaults.
// No dependencies; imported by every module of the bank but spcb_reach.
package spcb_pkg;

    // Default sizes of the bank.
    localparam int unsigned DEF_NUM_POINTS   = 32;
    localparam int unsigned DEF_NUM_BASES    = 8;
    localparam int unsigned DEF_THRESH_WIDTH = 16;
    localparam int unsigned DEF_NUM_LOCKS    = 8;

    // Field widths of one access word and one result word.
    localparam int unsigned IDX_W   = 5;
    localparam int unsigned VAL_W   = 32;
    localparam int unsigned TGT_W   = 3;
    localparam int unsigned BASE_W  = 16;

    // Stream widths: tdata is padded to whole bytes.
    localparam int unsigned S_TDATA_W = 40;
    localparam int unsigned S_TUSER_W = 1 + TGT_W;
    localparam int unsigned M_TDATA_W = 2 * VAL_W;

    // Access direction.
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Access targets.
    localparam logic [TGT_W-1:0] TGT_COUNTER = 3'd0;
    localparam logic [TGT_W-1:0] TGT_THRESH  = 3'd1;
    localparam logic [TGT_W-1:0] TGT_BASE    = 3'd2;
    localparam logic [TGT_W-1:0] TGT_LOCK    = 3'd3;
    localparam logic [TGT_W-1:0] TGT_INCR    = 3'd4;

endpackage

// ===== rtl/sync_point_counter_bank_unit.sv =====
// Top level of the sync point counter bank: register file, locks and sequencer.
// Depends on spcb_pkg and spcb_reach.
//
//  Channel   Dir  Handshake                 Payload
//  s (in)    in   i_s_tvalid / o_s_tready   tdata: index, value; tuser: op, target
//  m (out)   out  o_m_tvalid / i_m_tready   tdata: read_data, crossed_mask
//
// A single access passes through an execute state, an output state and the idle
// state before the next word is accepted. An increment mask walks every sync
// point through the shared threshold test unit, one point a cycle. The input is
// not ready while a word is in work or its result waits; a stalled output holds.
// Reset (synchronous, active low) clears all counters, thresholds, bases
// and locks at once.
module sync_point_counter_bank_unit #(
    parameter int unsigned NUM_POINTS   = spcb_pkg::DEF_NUM_POINTS,
    parameter int unsigned NUM_BASES    = spcb_pkg::DEF_NUM_BASES,
    parameter int unsigned THRESH_WIDTH = spcb_pkg::DEF_THRESH_WIDTH,
    parameter int unsigned NUM_LOCKS    = spcb_pkg::DEF_NUM_LOCKS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // index [4:0], value [36:5], zero pad [39:37]
    input  logic [spcb_pkg::S_TDATA_W-1:0] i_s_tdata,
    // op [0], target [3:1]
    input  logic [spcb_pkg::S_TUSER_W-1:0] i_s_tuser,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // read_data [31:0], crossed_mask [63:32]
    output logic [spcb_pkg::M_TDATA_W-1:0] o_m_tdata
);
    import spcb_pkg::*;

    localparam int unsigned PTR_W = (NUM_POINTS > 1) ? $clog2(NUM_POINTS) : 1;
    localparam int unsigned BS_W  = (NUM_BASES > 1)  ? $clog2(NUM_BASES)  : 1;
    localparam int unsigned LK_W  = (NUM_LOCKS > 1)  ? $clog2(NUM_LOCKS)  : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_OUT
    } t_state;

    // Storage.
    logic [VAL_W-1:0]        r_cnt  [NUM_POINTS];
    logic [THRESH_WIDTH-1:0] r_thr  [NUM_POINTS];
    logic [BASE_W-1:0]       r_base [NUM_BASES];
    logic [NUM_LOCKS-1:0]    r_lock, n_lock;

    // Sequencer and output registers.
    t_state           r_state, n_state;
    logic [PTR_W-1:0] r_ptr, n_ptr;
    logic             r_out_valid, n_out_valid;
    logic [VAL_W-1:0] r_rd, n_rd;
    logic [VAL_W-1:0] r_crossed, n_crossed;

    // Latched access word.
    logic             r_op;
    logic [TGT_W-1:0] r_tgt;
    logic [IDX_W-1:0] r_idx;
    logic [VAL_W-1:0] r_val;

    logic                    accept;
    logic                    pt_in, bs_in, lk_in;
    logic [PTR_W-1:0]        pt;
    logic [VAL_W-1:0]        cnt_sel;
    logic [THRESH_WIDTH-1:0] thr_sel;
    logic [THRESH_WIDTH-1:0] op_a, op_b;
    logic                    op_cin;
    logic                    reached;
    logic                    sweep_last;
    logic                    cnt_we, thr_we, base_we;
    logic [VAL_W-1:0]        cnt_wdata;

    assign accept     = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_crossed, r_rd};

    // Range checks of the latched index.
    assign pt_in = ({1'b0, r_idx} < (IDX_W + 1)'(NUM_POINTS));
    assign bs_in = ({1'b0, r_idx} < (IDX_W + 1)'(NUM_BASES));
    assign lk_in = ({1'b0, r_idx} < (IDX_W + 1)'(NUM_LOCKS));

    // The point under test: the sweep pointer for increments, else the index.
    assign pt      = (r_tgt == TGT_INCR) ? r_ptr : r_idx[PTR_W-1:0];
    assign cnt_sel = r_cnt[pt];
    assign thr_sel = r_thr[pt];

    assign sweep_last = (r_ptr == PTR_W'(NUM_POINTS - 1));

    // Operand selection for the shared threshold test.
    always_comb begin
        unique case (r_tgt)
            TGT_COUNTER: begin
                op_a   = thr_sel;
                op_b   = r_val[THRESH_WIDTH-1:0];
                op_cin = 1'b1;
            end
            TGT_THRESH: begin
                op_a   = r_val[THRESH_WIDTH-1:0];
                op_b   = cnt_sel[THRESH_WIDTH-1:0];
                op_cin = 1'b1;
            end
            default: begin
                // Tests counter + 1 against the threshold: thr - cnt - 1.
                op_a   = thr_sel;
                op_b   = cnt_sel[THRESH_WIDTH-1:0];
                op_cin = 1'b0;
            end
        endcase
    end

    spcb_reach #(
        .THRESH_WIDTH (THRESH_WIDTH)
    ) u_reach (
        .i_a       (op_a),
        .i_b       (op_b),
        .i_cin     (op_cin),
        .o_reached (reached)
    );

    // Storage write enables, valid only in the execute state of a write.
    always_comb begin
        cnt_we    = 1'b0;
        thr_we    = 1'b0;
        base_we   = 1'b0;
        cnt_wdata = r_val;
        if (r_state == S_EXEC && r_op == OP_WRITE) begin
            case (r_tgt)
                TGT_COUNTER: cnt_we = pt_in;
                TGT_THRESH:  thr_we = pt_in;
                TGT_BASE:    base_we = bs_in;
                TGT_INCR: begin
                    cnt_we    = r_val[r_ptr];
                    cnt_wdata = cnt_sel + VAL_W'(1);
                end
                default: ;
            endcase
        end
    end

    // Next state, results and lock bits.
    always_comb begin
        n_state     = r_state;
        n_ptr       = r_ptr;
        n_out_valid = r_out_valid;
        n_rd        = r_rd;
        n_crossed   = r_crossed;
        n_lock      = r_lock;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state   = S_EXEC;
                    n_ptr     = '0;
                    n_rd      = '0;
                    n_crossed = '0;
                end
            end
            S_EXEC: begin
                n_state     = S_OUT;
                n_out_valid = 1'b1;
                if (r_op == OP_READ) begin
                    case (r_tgt)
                        TGT_COUNTER: if (pt_in) n_rd = cnt_sel;
                        TGT_THRESH:  if (pt_in) n_rd = VAL_W'(thr_sel);
                        TGT_BASE:    if (bs_in) n_rd = VAL_W'(r_base[r_idx[BS_W-1:0]]);
                        TGT_LOCK: begin
                            if (lk_in && !r_lock[r_idx[LK_W-1:0]]) begin
                                n_lock[r_idx[LK_W-1:0]] = 1'b1;
                                n_rd = VAL_W'(1);
                            end
                        end
                        default: ;
                    endcase
                end else begin
                    case (r_tgt) inside
                        TGT_COUNTER, TGT_THRESH: begin
                            if (pt_in && reached) n_crossed = VAL_W'(1) << r_idx;
                        end
                        TGT_LOCK: begin
                            if (lk_in) n_lock[r_idx[LK_W-1:0]] = 1'b0;
                        end
                        TGT_INCR: begin
                            // Walk the points one a cycle until the last one.
                            if (r_val[r_ptr] && reached) begin
                                n_crossed = r_crossed | (VAL_W'(1) << r_ptr);
                            end
                            if (!sweep_last) begin
                                n_state     = S_EXEC;
                                n_out_valid = 1'b0;
                                n_ptr       = r_ptr + PTR_W'(1);
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_OUT: begin
                if (i_m_tready) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b0;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer state and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ptr       <= '0;
            r_out_valid <= 1'b0;
            r_rd        <= '0;
            r_crossed   <= '0;
            r_lock      <= '0;
        end else begin
            r_state     <= n_state;
            r_ptr       <= n_ptr;
            r_out_valid <= n_out_valid;
            r_rd        <= n_rd;
            r_crossed   <= n_crossed;
            r_lock      <= n_lock;
        end
    end

    // Access word capture.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= i_s_tuser[0];
            r_tgt <= i_s_tuser[TGT_W:1];
            r_idx <= i_s_tdata[IDX_W-1:0];
            r_val <= i_s_tdata[IDX_W+VAL_W-1:IDX_W];
        end
    end

    // Counter, threshold and base storage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_POINTS; i++) begin
                r_cnt[i] <= '0;
                r_thr[i] <= '0;
            end
            for (int i = 0; i < NUM_BASES; i++) begin
                r_base[i] <= '0;
            end
        end else begin
            if (cnt_we) begin
                r_cnt[pt] <= cnt_wdata;
            end
            if (thr_we) begin
                r_thr[pt] <= r_val[THRESH_WIDTH-1:0];
            end
            if (base_we) begin
                r_base[r_idx[BS_W-1:0]] <= r_val[BASE_W-1:0];
            end
        end
    end

endmodule

// ===== rtl/spcb_reach.sv =====
// Shared threshold test unit of the sync point counter bank.
// Computes the wrapped difference a - b (or a - b - 1) and the reached flag.
// Depends on nothing but its parameter.
module spcb_reach #(
    parameter int unsigned THRESH_WIDTH = 16
) (
    input  logic [THRESH_WIDTH-1:0] i_a,
    input  logic [THRESH_WIDTH-1:0] i_b,
    input  logic                    i_cin,
    output logic                    o_reached
);
    logic [THRESH_WIDTH-1:0] diff;

    // With carry in the unit subtracts; without it, it yields a - b - 1.
    assign diff = i_a + ~i_b + THRESH_WIDTH'(i_cin);

    // Reached when the top bit differs from "all lower bits are zero".
    assign o_reached = diff[THRESH_WIDTH-1] ^ (diff[THRESH_WIDTH-2:0] == '0);

endmodule

// ===== rtl/spcb_checker.sv =====
// Port-level checker for the sync point counter bank, bound to the top level.
// Depends on spcb_pkg and sync_point_counter_bank_unit.
module spcb_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_s_tvalid,
    input logic                           o_s_tready,
    input logic [spcb_pkg::S_TDATA_W-1:0] i_s_tdata,
    input logic [spcb_pkg::S_TUSER_W-1:0] i_s_tuser,
    input logic                           o_m_tvalid,
    input logic                           i_m_tready,
    input logic [spcb_pkg::M_TDATA_W-1:0] o_m_tdata
);
    import spcb_pkg::*;

    // Reset drops any pending result word.
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("result word valid after reset");

    // No new word is taken while a result waits.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !o_s_tready)
        else $error("input ready while result pending");

    // An accepted word closes the input until its result is delivered.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input ready right after accept");

    // A result carries read data or a crossed mask, never both.
    a_rd_or_crossed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[VAL_W-1:0] == '0 || o_m_tdata[M_TDATA_W-1:VAL_W] == '0))
        else $error("read data and crossed mask both nonzero");

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("stalled result word changed");

endmodule

bind sync_point_counter_bank_unit spcb_checker u_spcb_checker (.*);

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for sync_point_counter_bank_unit: streams access words in,
// takes each expected result word from a directed row or a mirror of the bank and checks it field by field.
// Depends on spcb_pkg and the RTL of the bank.
module tb;
    import spcb_pkg::*;

    localparam int unsigned NP = DEF_NUM_POINTS;
    localparam int unsigned NB = DEF_NUM_BASES;
    localparam int unsigned TW = DEF_THRESH_WIDTH;
    localparam int unsigned NL = DEF_NUM_LOCKS;

    localparam int unsigned IDX_MAX = (1 << IDX_W) - 1;
    localparam logic [TGT_W-1:0] TGT_SPARE_FIRST = 3'd5;
    localparam logic [TGT_W-1:0] TGT_SPARE_LAST = 3'd7;
    localparam logic [31:0] THR_MASK = 32'((64'd1 << TW) - 1);

    localparam int unsigned RANDOM_WORDS = 530;
    localparam int unsigned DRAIN_CYCLES = 2 * NP + 8;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned MAX_PRINTS = 100;
    localparam int unsigned IDLE_STRETCH = 40;

    // One access word and one result word; the result word is in stream bit order.
    typedef struct packed {
        logic             op;
        logic [TGT_W-1:0] tgt;
        logic [IDX_W-1:0] idx;
        logic [VAL_W-1:0] value;
    } t_access;

    typedef struct packed {
        logic [31:0] crossed;
        logic [31:0] rd;
    } t_result;

    typedef struct {
        t_access acc;
        bit      typed;
        t_result res;
    } t_dir_row;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [S_TUSER_W-1:0] s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b1;
    logic [M_TDATA_W-1:0] m_tdata;

    // Mirror of the bank state.
    logic [31:0]       cnt_mirror [NP];
    logic [TW-1:0]     thr_mirror [NP];
    logic [BASE_W-1:0] base_mirror [NB];
    logic [NL-1:0]     lock_mirror;

    t_result      pending_results [$];
    t_dir_row     dir_rows [$];
    int unsigned  mismatch_count = 0;
    int unsigned  sent_count = 0;
    int unsigned  cycle_count = 0;
    bit           src_idle = 1'b1;
    bit           sink_idle = 1'b1;

    sync_point_counter_bank_unit #(
        .NUM_POINTS  (NP),
        .NUM_BASES   (NB),
        .THRESH_WIDTH(TW),
        .NUM_LOCKS   (NL)
    ) DUT (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_s_tvalid(s_tvalid),
        .o_s_tready(s_tready),
        .i_s_tdata (s_tdata),
        .i_s_tuser (s_tuser),
        .o_m_tvalid(m_tvalid),
        .i_m_tready(m_tready),
        .o_m_tdata (m_tdata)
    );

    // Clock with a 2 ns period.
    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Watchdog on the whole run.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        if (mismatch_count < MAX_PRINTS)
            $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // A point has reached its threshold when the top bit of the wrapped
    // distance differs from the flag that all lower bits are zero.
    function automatic logic point_reached(int unsigned pt);
        logic [31:0] delta;
        delta = 32'(thr_mirror[pt]) - cnt_mirror[pt];
        return delta[TW-1] != (delta[TW-2:0] == '0);
    endfunction

    // Applies one access to the mirror and returns the result word it yields.
    function automatic t_result bank_access(input t_access a);
        t_result r;
        r = '0;
        if (a.op == OP_READ) begin
            case (a.tgt)
                TGT_COUNTER: if (a.idx < NP) r.rd = cnt_mirror[a.idx];
                TGT_THRESH:  if (a.idx < NP) r.rd = 32'(thr_mirror[a.idx]);
                TGT_BASE:    if (a.idx < NB) r.rd = 32'(base_mirror[a.idx]);
                TGT_LOCK: begin
                    if (a.idx < NL && !lock_mirror[a.idx]) begin
                        lock_mirror[a.idx] = 1'b1;
                        r.rd = 32'd1;
                    end
                end
                default: ;
            endcase
        end else begin
            case (a.tgt)
                TGT_COUNTER: begin
                    if (a.idx < NP) begin
                        cnt_mirror[a.idx] = a.value;
                        r.crossed[a.idx] = point_reached(a.idx);
                    end
                end
                TGT_THRESH: begin
                    if (a.idx < NP) begin
                        thr_mirror[a.idx] = a.value[TW-1:0];
                        r.crossed[a.idx] = point_reached(a.idx);
                    end
                end
                TGT_BASE: if (a.idx < NB) base_mirror[a.idx] = a.value[BASE_W-1:0];
                TGT_LOCK: if (a.idx < NL) lock_mirror[a.idx] = 1'b0;
                TGT_INCR: begin
                    for (int i = 0; i < NP; i++) begin
                        if (a.value[i]) begin
                            cnt_mirror[i] = cnt_mirror[i] + 32'd1;
                            r.crossed[i] = point_reached(i);
                        end
                    end
                end
                default: ;
            endcase
        end
        return r;
    endfunction

    // Random access word, biased toward counters sitting near their thresholds.
    function automatic t_access pick_access();
        t_access     a;
        int unsigned kind;
        logic [31:0] near;
        a.op = OP_WRITE;
        a.tgt = TGT_COUNTER;
        a.idx = IDX_W'($urandom_range(0, NP - 1));
        a.value = $urandom;
        kind = $urandom_range(0, 99);
        if (kind < 25) begin
            near = 32'(thr_mirror[a.idx]) + $urandom_range(0, 6) - 3;
            case ($urandom_range(0, 3))
                0: a.value = near;
                1: a.value = near - (32'd1 << (TW - 1));
                2: a.value = (a.value & ~THR_MASK) | (near & THR_MASK);
                default: ;
            endcase
        end else if (kind < 35) begin
            a.tgt = TGT_THRESH;
            if ($urandom_range(0, 1) == 1)
                a.value = (a.value & ~THR_MASK)
                        | ((cnt_mirror[a.idx] + $urandom_range(0, 4) - 2) & THR_MASK);
        end else if (kind < 55) begin
            a.tgt = TGT_INCR;
            case ($urandom_range(0, 3))
                0: a.value = $urandom & $urandom & $urandom;
                1: a.value = 32'd1 << $urandom_range(0, 31);
                2: a.value = '1;
                default: ;
            endcase
        end else if (kind < 70) begin
            a.op = OP_READ;
            a.tgt = ($urandom_range(0, 1) == 1) ? TGT_COUNTER : TGT_THRESH;
        end else if (kind < 80) begin
            a.op = 1'($urandom_range(0, 1));
            a.tgt = TGT_BASE;
            a.idx = IDX_W'(($urandom_range(0, 5) == 0) ? $urandom_range(NB, IDX_MAX)
                                                        : $urandom_range(0, NB - 1));
        end else if (kind < 92) begin
            a.op = 1'($urandom_range(0, 1));
            a.tgt = TGT_LOCK;
            a.idx = IDX_W'(($urandom_range(0, 5) == 0) ? $urandom_range(NL, IDX_MAX)
                                                        : $urandom_range(0, NL - 1));
        end else begin
            a.op = 1'($urandom_range(0, 1));
            a.tgt = TGT_W'($urandom_range(0, TGT_SPARE_LAST));
            a.idx = IDX_W'($urandom_range(0, IDX_MAX));
        end
        return a;
    endfunction

    task automatic add_row(input logic op, input logic [TGT_W-1:0] tgt,
                           input logic [IDX_W-1:0] idx, input logic [31:0] value,
                           input bit typed, input logic [31:0] rd,
                           input logic [31:0] crossed);
        t_dir_row row;
        row.acc = '{op: op, tgt: tgt, idx: idx, value: value};
        row.typed = typed;
        row.res = '{crossed: crossed, rd: rd};
        dir_rows.push_back(row);
    endtask

    // Sends one access word and queues the result word it should produce.
    // The valid stays high between back-to-back words.
    task automatic send_access(input t_access a, input t_result typed_res, input bit use_typed);
        int unsigned gap;
        t_result     predicted;
        if (sent_count % IDLE_STRETCH == 0)
            src_idle = ($urandom_range(0, 3) != 0);
        gap = src_idle ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {{(S_TDATA_W - VAL_W - IDX_W){1'b0}}, a.value, a.idx};
        s_tuser <= {a.tgt, a.op};
        do @(posedge clk); while (!s_tready);
        predicted = bank_access(a);
        pending_results.push_back(use_typed ? typed_res : predicted);
        sent_count++;
    endtask

    // Result side: random stalls, then each word is checked against the oldest expectation.
    initial begin
        int unsigned stall;
        int unsigned seen;
        t_result     got;
        t_result     want;
        seen = 0;
        while (!rst_n) @(posedge clk);
        forever begin
            if (seen % IDLE_STRETCH == 0)
                sink_idle = ($urandom_range(0, 3) != 0);
            stall = sink_idle ? $urandom_range(0, 4) : 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
                m_tready <= 1'b1;
            end
            do @(posedge clk); while (!m_tvalid);
            got = m_tdata;
            seen++;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected word read_data=%h crossed_mask=%h",
                                          got.rd, got.crossed));
            end else begin
                want = pending_results.pop_front();
                if (got.rd !== want.rd)
                    report_mismatch($sformatf("word %0d read_data %h, expected %h",
                                              seen, got.rd, want.rd));
                if (got.crossed !== want.crossed)
                    report_mismatch($sformatf("word %0d crossed_mask %h, expected %h",
                                              seen, got.crossed, want.crossed));
            end
        end
    end

    // Stimulus: reset, directed rows, random words, drain.
    initial begin
        for (int i = 0; i < NP; i++) begin
            cnt_mirror[i] = '0;
            thr_mirror[i] = '0;
        end
        for (int i = 0; i < NB; i++)
            base_mirror[i] = '0;
        lock_mirror = '0;

        // Reads after reset, lock acquire, hold and release.
        add_row(OP_READ,  TGT_COUNTER, 5'd0,  32'd0, 1, 32'd0, 32'd0);
        add_row(OP_READ,  TGT_THRESH,  5'd31, 32'd0, 1, 32'd0, 32'd0);
        add_row(OP_READ,  TGT_BASE,    5'd7,  32'd0, 1, 32'd0, 32'd0);
        add_row(OP_READ,  TGT_LOCK,    5'd0,  32'd0, 1, 32'd1, 32'd0);
        add_row(OP_READ,  TGT_LOCK,    5'd0,  32'd0, 1, 32'd0, 32'd0);
        add_row(OP_WRITE, TGT_LOCK,    5'd0,  32'd0, 1, 32'd0, 32'd0);
        add_row(OP_READ,  TGT_LOCK,    5'd0,  32'd0, 1, 32'd1, 32'd0);
        add_row(OP_READ,  TGT_LOCK,    5'd7,  32'd0, 1, 32'd1, 32'd0);
        // Counter wraps from all ones to zero and meets a zero threshold.
        add_row(OP_WRITE, TGT_COUNTER, 5'd0,  32'hFFFF_FFFF, 0, 32'd0, 32'd0);
        add_row(OP_WRITE, TGT_INCR,    5'd0,  32'h0000_0001, 1, 32'd0, 32'd1);
        // Threshold and base writes keep only their low bits.
        add_row(OP_WRITE, TGT_THRESH,  5'd1,  32'hFFFF_FFFF, 0, 32'd0, 32'd0);
        add_row(OP_READ,  TGT_THRESH,  5'd1,  32'd0, 1, 32'h0000_FFFF, 32'd0);
        add_row(OP_WRITE, TGT_BASE,    5'd7,  32'hFFFF_FFFF, 1, 32'd0, 32'd0);
        add_row(OP_READ,  TGT_BASE,    5'd7,  32'd0, 1, 32'h0000_FFFF, 32'd0);
        // Out of range indexes, increment mask read and unused targets.
        add_row(OP_WRITE, TGT_BASE,    5'd8,  32'h0000_1234, 1, 32'd0, 32'd0);
        add_row(OP_READ,  TGT_BASE,    5'd8,  32'd0, 1, 32'd0, 32'd0);
        add_row(OP_READ,  TGT_LOCK,    5'd8,  32'd0, 1, 32'd0, 32'd0);
        add_row(OP_WRITE, TGT_LOCK,    5'd31, 32'd0, 1, 32'd0, 32'd0);
        add_row(OP_READ,  TGT_INCR,    5'd0,  32'hFFFF_FFFF, 1, 32'd0, 32'd0);
        add_row(OP_WRITE, TGT_SPARE_FIRST, 5'd31, 32'hFFFF_FFFF, 1, 32'd0, 32'd0);
        add_row(OP_READ,  TGT_SPARE_LAST, 5'd31, 32'd0, 1, 32'd0, 32'd0);
        // Full increment mask and field extremes on the last point.
        add_row(OP_WRITE, TGT_INCR,    5'd0,  32'hFFFF_FFFF, 0, 32'd0, 32'd0);
        add_row(OP_WRITE, TGT_COUNTER, 5'd31, 32'h8000_0000, 0, 32'd0, 32'd0);
        add_row(OP_WRITE, TGT_THRESH,  5'd31, 32'h0000_8000, 0, 32'd0, 32'd0);
        add_row(OP_READ,  TGT_COUNTER, 5'd31, 32'd0, 1, 32'h8000_0000, 32'd0);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_access(dir_rows[i].acc, dir_rows[i].res, dir_rows[i].typed);

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            // Halfway through, hold off until the bank has answered everything.
            if (n == RANDOM_WORDS / 2) begin
                s_tvalid <= 1'b0;
                do @(posedge clk); while (pending_results.size() != 0);
            end
            send_access(pick_access(), '0, 1'b0);
        end
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
